/* design/frame_symmetry_match_defines.svh */
// Assertion macros shared by the frame symmetry match RTL.
`ifndef FRAME_SYMMETRY_MATCH_DEFINES_SVH
`define FRAME_SYMMETRY_MATCH_DEFINES_SVH
`ifndef SYNTH
`define FSMT_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame symmetry match check failed");
`define FSMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame symmetry match check failed");
`else
`define FSMT_ASSERT_HOLDS(lbl, ante, cons)
`define FSMT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/fsmt_pkg.sv */
// Types, widths and the cube rotation table for the frame symmetry match.
`default_nettype none

package fsmt_pkg;

  localparam int COMP_W    = 16;  // one signed Q1.14 component
  localparam int AXIS_W    = 3 * COMP_W;
  localparam int DIFF_W    = COMP_W + 1;
  localparam int SQ_W      = 2 * COMP_W + 1;  // square of a difference, up to 2^32
  localparam int ROW_W     = SQ_W + 1;        // sum of three squares
  localparam int ROT_W     = ROW_W + 2;       // sum of three rows
  localparam int DIST_W    = 34;
  localparam int NUM_ROT   = 24;
  localparam int ROT_IDX_W = 5;

  typedef struct packed {
    logic [2:0][AXIS_W-1:0] a;  // row 0 is the x axis
    logic [2:0][AXIS_W-1:0] b;
  } frame_t;

  // row distance for A row r against B axis k, k sign negative when last index is 1
  typedef logic [2:0][2:0][1:0][ROW_W-1:0] row_set_t;
  typedef logic [NUM_ROT-1:0][ROT_W-1:0] rot_set_t;

  typedef struct packed {
    logic [2:0][1:0] ax;
    logic [2:0]      neg;
  } rot_t;

  // Rotation n in generation order: i, p, j (j != i), q, last fastest.
  function automatic rot_t rot_sel(input int n);
    rot_t r;
    int   m;
    logic cyclic;
    r = '0;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      for (int p = 0; p < 2; p++) begin
        for (int j = 0; j < 3; j++) begin
          if (j != i) begin
            for (int q = 0; q < 2; q++) begin
              if (m == n) begin
                cyclic    = (j == i + 1) || (i == 2 && j == 0);
                r.ax[0]   = 2'(i);
                r.neg[0]  = (p == 0);
                r.ax[1]   = 2'(j);
                r.neg[1]  = (q == 1);
                r.ax[2]   = 2'(3 - i - j);
                r.neg[2]  = r.neg[0] ^ r.neg[1] ^ !cyclic;
              end
              m++;
            end
          end
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/fsmt_frame_if.sv */
// Frame pair channel: valid/ready handshake and six packed axis fields.
`default_nettype none

interface fsmt_frame_if import fsmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AXIS_W-1:0] frame_a_x_axis;
  logic [AXIS_W-1:0] frame_a_y_axis;
  logic [AXIS_W-1:0] frame_a_z_axis;
  logic [AXIS_W-1:0] frame_b_x_axis;
  logic [AXIS_W-1:0] frame_b_y_axis;
  logic [AXIS_W-1:0] frame_b_z_axis;

  modport source (
    output valid, frame_a_x_axis, frame_a_y_axis, frame_a_z_axis,
           frame_b_x_axis, frame_b_y_axis, frame_b_z_axis,
    input  ready
  );
  modport sink (
    input  valid, frame_a_x_axis, frame_a_y_axis, frame_a_z_axis,
           frame_b_x_axis, frame_b_y_axis, frame_b_z_axis,
    output ready
  );
endinterface

`default_nettype wire

/* design/fsmt_result_if.sv */
// Match result channel: valid/ready handshake, rotation index and distance.
`default_nettype none

interface fsmt_result_if import fsmt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ROT_IDX_W-1:0] rotation_index;
  logic [DIST_W-1:0]    best_distance;

  modport source (output valid, rotation_index, best_distance, input ready);
  modport sink (input valid, rotation_index, best_distance, output ready);
endinterface

`default_nettype wire

/* design/frame_symmetry_match.sv */
// Top level: matches frame A against the 24 cube rotations of frame B.
//
// Usage:
//   frames (sink): one item is a pair of frames, six 48-bit axes, each axis
//   three signed Q1.14 components with x in the low bits.
//   result (source): one item per accepted pair, the index 0..23 of the
//   rotation of B closest to A and its summed squared difference in unsigned Q6.28,
//   saturated to 34 bits. Ties go to the lowest index.
// Pipeline: seven register stages, in order differences, squares, row sums,
//   rotation sums and the three levels of the minimum tree.
// Throughput: one pair per cycle while nothing stalls; every stage is a full
//   register with its own valid bit and computes its part of the work combinationally.
// Reset: rst (synchronous, active high) empties the pipeline; no other state.
// Stall: when result.ready is low the last stage holds its item and the stages
//   behind it keep filling bubbles; frames.ready drops only when every stage
//   is full.
`default_nettype none

module frame_symmetry_match import fsmt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  fsmt_frame_if.sink         frames,
  fsmt_result_if.source      result
);

  frame_t   frame;
  row_set_t rows;
  rot_set_t sums;
  logic     row_valid, row_ready;
  logic     sum_valid, sum_ready;

  assign frame.a[0] = frames.frame_a_x_axis;
  assign frame.a[1] = frames.frame_a_y_axis;
  assign frame.a[2] = frames.frame_a_z_axis;
  assign frame.b[0] = frames.frame_b_x_axis;
  assign frame.b[1] = frames.frame_b_y_axis;
  assign frame.b[2] = frames.frame_b_z_axis;

  fsmt_row_dist u_row_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frames.valid),
    .in_ready  (frames.ready),
    .frame     (frame),
    .out_valid (row_valid),
    .out_ready (row_ready),
    .rows      (rows)
  );

  fsmt_rot_sum u_rot_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (row_valid),
    .in_ready  (row_ready),
    .rows      (rows),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .sums      (sums)
  );

  fsmt_min_tree u_min_tree (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (sum_valid),
    .in_ready       (sum_ready),
    .sums           (sums),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .rotation_index (result.rotation_index),
    .best_distance  (result.best_distance)
  );

endmodule

`default_nettype wire

/* design/fsmt_row_dist.sv */
// Row distances: differences, squares and per-row sums over three stages.
`default_nettype none
`include "frame_symmetry_match_defines.svh"

module fsmt_row_dist import fsmt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  frame_t   frame,
  output logic     out_valid,
  input  logic     out_ready,
  output row_set_t rows
);

  logic signed [COMP_W-1:0] a_c [3][3];
  logic signed [COMP_W-1:0] b_c [3][3];
  logic signed [DIFF_W-1:0] diff_next [3][3][2][3];
  logic signed [DIFF_W-1:0] diff [3][3][2][3];
  logic [2:0][2:0][1:0][2:0][SQ_W-1:0] sq_next;
  logic [2:0][2:0][1:0][2:0][SQ_W-1:0] sq;
  row_set_t rows_next;

  logic d_valid, q_valid, s_valid;
  logic d_ready, q_ready, s_ready;

  assign s_ready   = !s_valid || out_ready;
  assign q_ready   = !q_valid || s_ready;
  assign d_ready   = !d_valid || q_ready;
  assign in_ready  = d_ready;
  assign out_valid = s_valid;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a_c[r][c] = frame.a[r][COMP_W*c +: COMP_W];
        b_c[r][c] = frame.b[r][COMP_W*c +: COMP_W];
      end
    end
  end

  // a - b for a positive sign, a + b for a negative one; -2.0 negates exactly
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          diff_next[r][k][0][c] = DIFF_W'(a_c[r][c]) - DIFF_W'(b_c[k][c]);
          diff_next[r][k][1][c] = DIFF_W'(a_c[r][c]) + DIFF_W'(b_c[k][c]);
        end
      end
    end
  end

  always_comb begin
    logic signed [2*DIFF_W-1:0] prod;
    prod = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        for (int n = 0; n < 2; n++) begin
          for (int c = 0; c < 3; c++) begin
            prod = diff[r][k][n][c] * diff[r][k][n][c];
            sq_next[r][k][n][c] = prod[SQ_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        for (int n = 0; n < 2; n++) begin
          rows_next[r][k][n] = ROW_W'(sq[r][k][n][0]) + ROW_W'(sq[r][k][n][1])
                             + ROW_W'(sq[r][k][n][2]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      q_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (d_ready) d_valid <= in_valid;
      if (q_ready) q_valid <= d_valid;
      if (s_ready) s_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) diff <= diff_next;
    if (q_ready) sq <= sq_next;
    if (s_ready) rows <= rows_next;
  end

  `FSMT_ASSERT_NEXT(a_sq_held_on_stall, q_valid && !s_ready, q_valid && $stable(sq))

endmodule

`default_nettype wire

/* design/fsmt_rot_sum.sv */
// Rotation sums: adds the three selected row distances for each of 24 rotations.
`default_nettype none
`include "frame_symmetry_match_defines.svh"

module fsmt_rot_sum import fsmt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  row_set_t rows,
  output logic     out_valid,
  input  logic     out_ready,
  output rot_set_t sums
);

  rot_set_t sums_next;
  logic     valid;
  logic     ready;

  assign ready     = !valid || out_ready;
  assign in_ready  = ready;
  assign out_valid = valid;

  for (genvar g = 0; g < NUM_ROT; g++) begin : g_rot
    localparam rot_t R = rot_sel(g);
    assign sums_next[g] = ROT_W'(rows[0][R.ax[0]][R.neg[0]])
                        + ROT_W'(rows[1][R.ax[1]][R.neg[1]])
                        + ROT_W'(rows[2][R.ax[2]][R.neg[2]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) sums <= sums_next;
  end

  `FSMT_ASSERT_NEXT(a_sums_held_on_stall, valid && !out_ready, valid && $stable(sums))

endmodule

`default_nettype wire

/* design/fsmt_min_tree.sv */
// Registered minimum tree over the 24 rotation sums, lowest index wins ties.
`default_nettype none
`include "frame_symmetry_match_defines.svh"

module fsmt_min_tree import fsmt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rot_set_t             sums,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROT_IDX_W-1:0] rotation_index,
  output logic [DIST_W-1:0]    best_distance
);

  localparam int GROUPS_A = NUM_ROT / 4;

  typedef struct packed {
    logic [ROT_IDX_W-1:0] idx;
    logic [ROT_W-1:0]     distance;
  } cand_t;

  // lo always carries the lower index, so only a strictly smaller hi wins
  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    return (hi.distance < lo.distance) ? hi : lo;
  endfunction

  cand_t grp [4];
  cand_t a_next [GROUPS_A];
  cand_t stage_a [GROUPS_A];
  cand_t b_next [2];
  cand_t stage_b [2];
  cand_t fin;

  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready;

  assign c_ready   = !c_valid || out_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign in_ready  = a_ready;
  assign out_valid = c_valid;

  always_comb begin
    for (int g = 0; g < GROUPS_A; g++) begin
      for (int m = 0; m < 4; m++) begin
        grp[m].idx      = ROT_IDX_W'(4 * g + m);
        grp[m].distance = sums[4 * g + m];
      end
      a_next[g] = pick(pick(grp[0], grp[1]), pick(grp[2], grp[3]));
    end
  end

  assign b_next[0] = pick(pick(stage_a[0], stage_a[1]), stage_a[2]);
  assign b_next[1] = pick(pick(stage_a[3], stage_a[4]), stage_a[5]);
  assign fin       = pick(stage_b[0], stage_b[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) stage_a <= a_next;
    if (b_ready) stage_b <= b_next;
    if (c_ready) begin
      rotation_index <= fin.idx;
      // saturate; the index above was chosen on the exact sum
      best_distance  <= (|fin.distance[ROT_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                        : fin.distance[DIST_W-1:0];
    end
  end

  `FSMT_ASSERT_HOLDS(a_index_in_range, c_valid, rotation_index <= ROT_IDX_W'(NUM_ROT - 1))
  `FSMT_ASSERT_NEXT(a_stage_b_kept, b_valid && !c_ready, b_valid)

endmodule

`default_nettype wire

/* sim/fsmt_match_checker.sv */
`timescale 1ns / 100ps
// Match checker: predicts the closest cube rotation for each accepted pair and checks results.
module fsmt_match_checker import fsmt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  fsmt_frame_if  frames,
  fsmt_result_if result,
  output int     mismatches,
  output int     pending
);

  localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 64'd1;

  typedef struct packed {
    logic [ROT_IDX_W-1:0] idx;
    logic [DIST_W-1:0]    distance;
  } match_t;

  match_t best_match_q[$];

  function automatic longint signed comp(input logic [AXIS_W-1:0] axis, input int c);
    return longint'($signed(axis[c*COMP_W +: COMP_W]));
  endfunction

  // Walks the rotations as lead axis, lead sign, second axis, second sign;
  // the third row is the cross product of the first two.
  function automatic match_t best_rotation(input frame_t f);
    longint signed   d;
    longint unsigned sum;
    longint unsigned best;
    int              n;
    int              sel[3];
    int              sgn[3];
    match_t          m;
    n    = 0;
    best = 0;
    m    = '0;
    for (int i = 0; i < 3; i++) begin
      for (int p = 0; p < 2; p++) begin
        for (int j = 0; j < 3; j++) begin
          if (j != i) begin
            for (int q = 0; q < 2; q++) begin
              sel[0] = i;
              sel[1] = j;
              sel[2] = 3 - i - j;
              sgn[0] = p ? 1 : -1;
              sgn[1] = q ? -1 : 1;
              sgn[2] = sgn[0] * sgn[1] * ((j == (i + 1) % 3) ? 1 : -1);
              sum = 0;
              for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                  d = comp(f.a[r], c) - longint'(sgn[r]) * comp(f.b[sel[r]], c);
                  sum += longint'(d * d);
                end
              end
              if (n == 0 || sum < best) begin
                best  = sum;
                m.idx = ROT_IDX_W'(n);
              end
              n++;
            end
          end
        end
      end
    end
    m.distance = (best > DIST_SAT) ? DIST_W'(DIST_SAT) : best[DIST_W-1:0];
    return m;
  endfunction

  always @(posedge clk) begin : watch
    frame_t f;
    match_t want;
    int     errs;
    errs = 0;
    if (rst) begin
      best_match_q.delete();
      pending    <= 0;
      mismatches <= 0;
    end else begin
      if (frames.valid && frames.ready) begin
        f.a[0] = frames.frame_a_x_axis;
        f.a[1] = frames.frame_a_y_axis;
        f.a[2] = frames.frame_a_z_axis;
        f.b[0] = frames.frame_b_x_axis;
        f.b[1] = frames.frame_b_y_axis;
        f.b[2] = frames.frame_b_z_axis;
        best_match_q.insert(best_match_q.size(), best_rotation(f));
      end
      if (result.valid && result.ready) begin
        if (best_match_q.size() == 0) begin
          $display("%0t: result item with no pair pending: rotation_index %0d best_distance %0d",
                   $time, result.rotation_index, result.best_distance);
          errs++;
        end else begin
          want = best_match_q.pop_front();
          if (result.rotation_index !== want.idx) begin
            $display("%0t: rotation_index expected %0d, got %0d",
                     $time, want.idx, result.rotation_index);
            errs++;
          end
          if (result.best_distance !== want.distance) begin
            $display("%0t: best_distance expected %0d, got %0d",
                     $time, want.distance, result.best_distance);
            errs++;
          end
        end
      end
      pending    <= best_match_q.size();
      mismatches <= mismatches + errs;
    end
  end

endmodule

/* sim/tb_frame_symmetry_match.sv */
`timescale 1ns / 100ps
// Testbench top: drives frame pairs and result backpressure, and reports the verdict.
module tb_frame_symmetry_match;
  import fsmt_pkg::*;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  bit   sender_calm;
  bit   receiver_calm;
  bit   hold_req;

  fsmt_frame_if  frames();
  fsmt_result_if result();

  frame_symmetry_match i_dut (
    .clk    (clk),
    .rst    (rst),
    .frames (frames),
    .result (result)
  );

  fsmt_match_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .frames     (frames),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("tb_frame_symmetry_match failed");
    $finish;
  end

  // Unit axes in Q1.14, x in the low component.
  localparam logic [AXIS_W-1:0] UNIT_X = {16'h0000, 16'h0000, 16'h4000};
  localparam logic [AXIS_W-1:0] UNIT_Y = {16'h0000, 16'h4000, 16'h0000};
  localparam logic [AXIS_W-1:0] UNIT_Z = {16'h4000, 16'h0000, 16'h0000};

  function automatic logic [COMP_W-1:0] pick_comp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hC000;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis();
    return {pick_comp(), pick_comp(), pick_comp()};
  endfunction

  function automatic logic [AXIS_W-1:0] negate_axis(input logic [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] o;
    for (int c = 0; c < 3; c++) o[c*COMP_W +: COMP_W] = -v[c*COMP_W +: COMP_W];
    return o;
  endfunction

  function automatic logic [AXIS_W-1:0] jitter_axis(input logic [AXIS_W-1:0] v, input int amp);
    logic [AXIS_W-1:0] o;
    for (int c = 0; c < 3; c++)
      o[c*COMP_W +: COMP_W] = v[c*COMP_W +: COMP_W] + COMP_W'($urandom_range(0, 2 * amp))
                              - COMP_W'(amp);
    return o;
  endfunction

  function automatic logic [AXIS_W-1:0] scale_axis(input logic [AXIS_W-1:0] v, input int s);
    logic [AXIS_W-1:0] o;
    for (int c = 0; c < 3; c++)
      o[c*COMP_W +: COMP_W] = (v[c*COMP_W +: COMP_W] == 16'h4000) ? COMP_W'(s) : 16'h0000;
    return o;
  endfunction

  // B built so that rotation n maps it exactly onto A.
  function automatic frame_t rotated_pair(input logic [2:0][AXIS_W-1:0] a, input int n);
    frame_t f;
    rot_t   rs;
    rs  = rot_sel(n);
    f.a = a;
    f.b = '0;
    for (int r = 0; r < 3; r++) f.b[rs.ax[r]] = rs.neg[r] ? negate_axis(a[r]) : a[r];
    return f;
  endfunction

  function automatic frame_t random_pair();
    frame_t                  f;
    logic [2:0][AXIS_W-1:0]  base;
    logic [2:0][AXIS_W-1:0]  a;
    rot_t                    ra;
    int                      s;
    int                      amp;
    if ($urandom_range(0, 3) == 0) begin
      for (int r = 0; r < 3; r++) begin
        f.a[r] = pick_axis();
        f.b[r] = pick_axis();
      end
    end else begin
      s       = ($urandom_range(0, 1) == 0) ? 16384 : $urandom_range(1, 32767);
      base[0] = scale_axis(UNIT_X, s);
      base[1] = scale_axis(UNIT_Y, s);
      base[2] = scale_axis(UNIT_Z, s);
      ra      = rot_sel($urandom_range(0, NUM_ROT - 1));
      for (int r = 0; r < 3; r++)
        a[r] = ra.neg[r] ? negate_axis(base[ra.ax[r]]) : base[ra.ax[r]];
      f   = rotated_pair(a, $urandom_range(0, NUM_ROT - 1));
      amp = 1 << $urandom_range(0, 12);
      for (int r = 0; r < 3; r++) begin
        f.a[r] = jitter_axis(f.a[r], amp);
        f.b[r] = jitter_axis(f.b[r], amp);
      end
    end
    return f;
  endfunction

  task automatic send_pair(input frame_t f);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      frames.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frames.valid          <= 1'b1;
    frames.frame_a_x_axis <= f.a[0];
    frames.frame_a_y_axis <= f.a[1];
    frames.frame_a_z_axis <= f.a[2];
    frames.frame_b_x_axis <= f.b[0];
    frames.frame_b_y_axis <= f.b[1];
    frames.frame_b_z_axis <= f.b[2];
    do @(posedge clk); while (!frames.ready);
  endtask

  task automatic drain();
    frames.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stall per item, plus one long hold-off on request.
  initial begin : sink_side
    int stall;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 80;
      end else begin
        stall = receiver_calm ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  initial begin : source_side
    frame_t                 f;
    logic [2:0][AXIS_W-1:0] ident;
    sender_calm           = 1'b0;
    receiver_calm         = 1'b0;
    hold_req              = 1'b0;
    rst                   <= 1'b1;
    frames.valid          <= 1'b0;
    frames.frame_a_x_axis <= '0;
    frames.frame_a_y_axis <= '0;
    frames.frame_a_z_axis <= '0;
    frames.frame_b_x_axis <= '0;
    frames.frame_b_y_axis <= '0;
    frames.frame_b_z_axis <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all zero: every rotation ties, lowest index wins
    f = '0;
    send_pair(f);
    // A all -2.0 against zero B: every rotation ties at 36.0
    f.a = {3{{3{16'h8000}}}};
    f.b = '0;
    send_pair(f);
    // negating -2.0 in B
    f.a = {3{{3{16'h7FFF}}}};
    f.b = {3{{3{16'h8000}}}};
    send_pair(f);
    f.a = {3{{3{16'h8000}}}};
    send_pair(f);
    f.a = {3{{3{16'h7FFF}}}};
    f.b = {3{{3{16'h7FFF}}}};
    send_pair(f);
    // each rotation wins once on an exact unit frame
    ident[0] = UNIT_X;
    ident[1] = UNIT_Y;
    ident[2] = UNIT_Z;
    for (int n = 0; n < NUM_ROT; n++) send_pair(rotated_pair(ident, n));

    for (int blk = 0; blk < 33; blk++) begin
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      if (blk == 8 || blk == 20) begin
        // back up the pipe: result side holds off while pairs keep coming
        hold_req    = 1'b1;
        sender_calm = 1'b1;
      end
      if (blk == 14 || blk == 26) drain();
      for (int k = 0; k < 50; k++) send_pair(random_pair());
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb_frame_symmetry_match passed");
    else
      $display("tb_frame_symmetry_match failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/fsmt_pkg.sv
design/fsmt_frame_if.sv
design/fsmt_result_if.sv
design/fsmt_row_dist.sv
design/fsmt_rot_sum.sv
design/fsmt_min_tree.sv
design/frame_symmetry_match.sv
sim/fsmt_match_checker.sv
sim/tb_frame_symmetry_match.sv
